// ----- hdl/sle_pkg.sv -----
// Shared constants, codes and helper functions for the sequence list editor.
// Used by sequence_list_editor_top, sle_list_checker and the testbench top; depends on nothing else.
package sle_pkg;

    localparam int DEPTH      = 64;
    localparam int COLOR_BITS = 16;

    // Fixed port widths.
    localparam int MODE_W   = 3;
    localparam int CODE_W   = 16;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    // Derived storage widths.
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [COLOR_BITS-1:0] entry_t;
    typedef logic [CNT_W-1:0]      count_t;
    typedef logic [CMP_W-1:0]      cmp_t;

    localparam logic [MODE_W-1:0] MODE_INSERT      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ERASE_POS   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ERASE_COLOR = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REVERSE     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SHOW        = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Keep the low COLOR_BITS of an input code, zero-filling when the store is wider.
    function automatic entry_t code_to_entry(input logic [CODE_W-1:0] code);
        entry_t e;
        e = '0;
        for (int b = 0; b < COLOR_BITS; b++) begin
            if (b < CODE_W) begin
                e[b] = code[b];
            end
        end
        return e;
    endfunction

    function automatic logic [CODE_W-1:0] entry_to_code(input entry_t e);
        logic [CODE_W-1:0] c;
        c = '0;
        for (int b = 0; b < CODE_W; b++) begin
            if (b < COLOR_BITS) begin
                c[b] = e[b];
            end
        end
        return c;
    endfunction

    function automatic logic [LEN_W-1:0] count_to_len(input count_t n);
        logic [LEN_W-1:0] l;
        l = '0;
        for (int b = 0; b < LEN_W; b++) begin
            if (b < CNT_W) begin
                l[b] = n[b];
            end
        end
        return l;
    endfunction

endpackage

// ----- hdl/sequence_list_editor_top.sv -----
// Top level of the sequence list editor: sequencer, entry memory and result register.
// Depends on sle_pkg.
//
// The block holds an ordered list of up to DEPTH colour codes in a memory with
// one read port and one write port (one read and one write a cycle, registered
// read data) and edits it with a small sequencer that moves one entry per step.
// One input transfer is taken only while the sequencer is idle; a result still
// waiting on the output does not hold off the next input. An insert places the
// code at its slot clipped to n (the list length), erase at position takes the
// position clipped to n, erase by colour packs the kept entries down, reverse
// swaps one pair of entries at a time and show sends one result per entry,
// holding while the output stalls. A refused insert, an edit that changes
// nothing or an unused mode goes straight to its single reply. Every moved
// entry needs one read and one write from the memory.
module sequence_list_editor_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sle_pkg::MODE_W-1:0]    s_mode,
    input  logic [sle_pkg::CODE_W-1:0]    s_color_code,
    input  logic [sle_pkg::POS_W-1:0]     s_position,
    input  logic [sle_pkg::POS_W-1:0]     s_position_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sle_pkg::CODE_W-1:0]    m_out_color,
    output logic                          m_last,
    output logic [sle_pkg::STATUS_W-1:0]  m_status,
    output logic [sle_pkg::LEN_W-1:0]     m_length
);
    import sle_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_WR,
        ST_ERA_CHK,
        ST_ERA_WR,
        ST_ECL_CHK,
        ST_ECL_WR,
        ST_REV_CHK,
        ST_REV_RB,
        ST_REV_WA,
        ST_REV_WB,
        ST_SHOW_RD,
        ST_SHOW_OUT,
        ST_RESP
    } state_t;

    state_t               state_reg;
    count_t               count_reg;
    count_t               i_reg;
    count_t               j_reg;
    count_t               p_reg;
    entry_t               color_reg;
    entry_t               tmp_reg;
    logic [STATUS_W-1:0]  status_reg;

    logic                 m_valid_reg;
    logic [CODE_W-1:0]    m_color_reg;
    logic                 m_last_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [LEN_W-1:0]     m_length_reg;

    // Entry memory.
    entry_t               mem [DEPTH];
    entry_t               rd_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    entry_t               wr_data;

    logic                 in_fire;
    logic                 out_free;
    logic                 m_load;
    cmp_t                 pos_ext;
    cmp_t                 pend_ext;
    cmp_t                 cnt_ext;
    cmp_t                 pos_clip;
    cmp_t                 pend_clip;
    count_t               i_plus;
    count_t               i_minus;

    assign s_ready     = (state_reg == ST_IDLE);
    assign in_fire     = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign m_load      = out_free && (state_reg inside {ST_SHOW_OUT, ST_RESP});
    assign m_valid     = m_valid_reg;
    assign m_out_color = m_color_reg;
    assign m_last      = m_last_reg;
    assign m_status    = m_status_reg;
    assign m_length    = m_length_reg;

    assign pos_ext   = CMP_W'(s_position);
    assign pend_ext  = CMP_W'(s_position_end);
    assign cnt_ext   = CMP_W'(count_reg);
    assign pos_clip  = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;
    assign pend_clip = (pend_ext > cnt_ext) ? cnt_ext : pend_ext;
    assign i_plus    = i_reg + count_t'(1);
    assign i_minus   = i_reg - count_t'(1);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Memory port control for each sequencer step.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = i_reg[ADDR_W-1:0];
        wr_en   = 1'b0;
        wr_addr = i_reg[ADDR_W-1:0];
        wr_data = rd_data;
        case (state_reg)
            ST_INS_CHK: begin
                if (i_reg > p_reg) begin
                    rd_en   = 1'b1;
                    rd_addr = i_minus[ADDR_W-1:0];
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = p_reg[ADDR_W-1:0];
                    wr_data = color_reg;
                end
            end
            ST_INS_WR: begin
                wr_en = 1'b1;
            end
            ST_ERA_CHK: begin
                rd_en   = (i_plus < count_reg);
                rd_addr = i_plus[ADDR_W-1:0];
            end
            ST_ERA_WR: begin
                wr_en = 1'b1;
            end
            ST_ECL_CHK: begin
                rd_en = (i_reg < count_reg);
            end
            ST_ECL_WR: begin
                wr_en   = (rd_data != color_reg);
                wr_addr = j_reg[ADDR_W-1:0];
            end
            ST_REV_CHK: begin
                rd_en = (i_reg < j_reg);
            end
            ST_REV_RB: begin
                rd_en   = 1'b1;
                rd_addr = j_reg[ADDR_W-1:0];
            end
            ST_REV_WA: begin
                wr_en = 1'b1;
            end
            ST_REV_WB: begin
                wr_en   = 1'b1;
                wr_addr = j_reg[ADDR_W-1:0];
                wr_data = tmp_reg;
            end
            ST_SHOW_RD: begin
                rd_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !m_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        color_reg <= code_to_entry(s_color_code);
                        case (s_mode)
                            MODE_INSERT: begin
                                if (count_reg == count_t'(DEPTH)) begin
                                    status_reg <= STATUS_FULL;
                                    state_reg  <= ST_RESP;
                                end else begin
                                    status_reg <= STATUS_OK;
                                    p_reg      <= count_t'(pos_clip);
                                    i_reg      <= count_reg;
                                    state_reg  <= ST_INS_CHK;
                                end
                            end
                            MODE_ERASE_POS: begin
                                status_reg <= STATUS_OK;
                                if (pos_ext != '0 && count_reg != '0) begin
                                    i_reg     <= count_t'(pos_clip - cmp_t'(1));
                                    state_reg <= ST_ERA_CHK;
                                end else begin
                                    state_reg <= ST_RESP;
                                end
                            end
                            MODE_ERASE_COLOR: begin
                                status_reg <= STATUS_OK;
                                i_reg      <= '0;
                                j_reg      <= '0;
                                state_reg  <= ST_ECL_CHK;
                            end
                            MODE_REVERSE: begin
                                status_reg <= STATUS_OK;
                                if (pos_ext != '0 && pos_ext <= cnt_ext && pos_ext <= pend_clip)
                                begin
                                    i_reg     <= count_t'(pos_ext - cmp_t'(1));
                                    j_reg     <= count_t'(pend_clip - cmp_t'(1));
                                    state_reg <= ST_REV_CHK;
                                end else begin
                                    state_reg <= ST_RESP;
                                end
                            end
                            MODE_SHOW: begin
                                if (count_reg == '0) begin
                                    status_reg <= STATUS_EMPTY;
                                    state_reg  <= ST_RESP;
                                end else begin
                                    status_reg <= STATUS_OK;
                                    i_reg      <= '0;
                                    state_reg  <= ST_SHOW_RD;
                                end
                            end
                            default: begin
                                status_reg <= STATUS_OK;
                                state_reg  <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_INS_CHK: begin
                    if (i_reg > p_reg) begin
                        state_reg <= ST_INS_WR;
                    end else begin
                        count_reg <= count_reg + count_t'(1);
                        state_reg <= ST_RESP;
                    end
                end
                ST_INS_WR: begin
                    i_reg     <= i_minus;
                    state_reg <= ST_INS_CHK;
                end
                ST_ERA_CHK: begin
                    if (i_plus < count_reg) begin
                        state_reg <= ST_ERA_WR;
                    end else begin
                        count_reg <= count_reg - count_t'(1);
                        state_reg <= ST_RESP;
                    end
                end
                ST_ERA_WR: begin
                    i_reg     <= i_plus;
                    state_reg <= ST_ERA_CHK;
                end
                ST_ECL_CHK: begin
                    if (i_reg < count_reg) begin
                        state_reg <= ST_ECL_WR;
                    end else begin
                        count_reg <= j_reg;
                        state_reg <= ST_RESP;
                    end
                end
                ST_ECL_WR: begin
                    // Kept entries are packed down to the write pointer.
                    if (rd_data != color_reg) begin
                        j_reg <= j_reg + count_t'(1);
                    end
                    i_reg     <= i_plus;
                    state_reg <= ST_ECL_CHK;
                end
                ST_REV_CHK: begin
                    state_reg <= (i_reg < j_reg) ? ST_REV_RB : ST_RESP;
                end
                ST_REV_RB: begin
                    tmp_reg   <= rd_data;
                    state_reg <= ST_REV_WA;
                end
                ST_REV_WA: begin
                    state_reg <= ST_REV_WB;
                end
                ST_REV_WB: begin
                    i_reg     <= i_plus;
                    j_reg     <= j_reg - count_t'(1);
                    state_reg <= ST_REV_CHK;
                end
                ST_SHOW_RD: begin
                    state_reg <= ST_SHOW_OUT;
                end
                ST_SHOW_OUT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_color_reg  <= entry_to_code(rd_data);
                        m_last_reg   <= (i_plus == count_reg);
                        m_status_reg <= STATUS_OK;
                        m_length_reg <= count_to_len(count_reg);
                        if (i_plus == count_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            i_reg     <= i_plus;
                            state_reg <= ST_SHOW_RD;
                        end
                    end
                end
                ST_RESP: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_color_reg  <= '0;
                        m_last_reg   <= 1'b1;
                        m_status_reg <= status_reg;
                        m_length_reg <= count_to_len(count_reg);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- tb/sle_list_checker.sv -----
// Result checker for the sequence list editor: keeps its own copy of the list,
// predicts the replies to every accepted edit and compares them with the output.
// Depends on sle_pkg for port widths, mode and status codes.
`timescale 1ns / 1ps

module sle_list_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [sle_pkg::MODE_W-1:0]    s_mode,
    input  logic [sle_pkg::CODE_W-1:0]    s_color_code,
    input  logic [sle_pkg::POS_W-1:0]     s_position,
    input  logic [sle_pkg::POS_W-1:0]     s_position_end,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [sle_pkg::CODE_W-1:0]    m_out_color,
    input  logic                          m_last,
    input  logic [sle_pkg::STATUS_W-1:0]  m_status,
    input  logic [sle_pkg::LEN_W-1:0]     m_length,
    output int                            mismatches,
    output int                            outstanding,
    output int                            items_seen,
    output int                            results_seen,
    output int                            peak_length,
    output int                            full_refusals
);
    import sle_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0]   color;
        logic                last;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    len;
    } reply_t;

    logic [CODE_W-1:0] list_codes [DEPTH];
    int unsigned       list_len;
    reply_t            replies_due [$];

    initial begin
        mismatches    = 0;
        outstanding   = 0;
        items_seen    = 0;
        results_seen  = 0;
        peak_length   = 0;
        full_refusals = 0;
        list_len      = 0;
    end

    task automatic queue_reply(input logic [CODE_W-1:0] color, input logic last,
                               input logic [STATUS_W-1:0] status);
        reply_t r;
        r.color  = color;
        r.last   = last;
        r.status = status;
        r.len    = LEN_W'(list_len);
        replies_due.push_back(r);
    endtask

    // Applies one edit to the local list and queues the replies it should produce.
    task automatic edit_list(input logic [MODE_W-1:0] mode, input logic [CODE_W-1:0] code,
                             input logic [POS_W-1:0] pos, input logic [POS_W-1:0] pos_end);
        int unsigned n, p, e, i, j;
        logic [CODE_W-1:0]   held;
        logic [STATUS_W-1:0] st;
        n  = list_len;
        p  = pos;
        e  = pos_end;
        st = STATUS_OK;
        case (mode)
            MODE_INSERT: begin
                if (n >= DEPTH) begin
                    st = STATUS_FULL;
                    full_refusals++;
                end else begin
                    if (p > n) p = n;
                    for (i = n; i > p; i--) list_codes[i] = list_codes[i-1];
                    list_codes[p] = code;
                    list_len = n + 1;
                end
            end
            MODE_ERASE_POS: begin
                if (p != 0 && n != 0) begin
                    if (p > n) p = n;
                    for (i = p - 1; i + 1 < n; i++) list_codes[i] = list_codes[i+1];
                    list_len = n - 1;
                end
            end
            MODE_ERASE_COLOR: begin
                j = 0;
                for (i = 0; i < n; i++) begin
                    if (list_codes[i] != code) begin
                        list_codes[j] = list_codes[i];
                        j++;
                    end
                end
                list_len = j;
            end
            MODE_REVERSE: begin
                if (e > n) e = n;
                // A range that starts at zero, past the end or after its own end is ignored.
                if (!(p == 0 || p > n || p > e)) begin
                    i = p - 1;
                    j = e - 1;
                    while (i < j) begin
                        held          = list_codes[i];
                        list_codes[i] = list_codes[j];
                        list_codes[j] = held;
                        i++;
                        j--;
                    end
                end
            end
            default: ;
        endcase
        if (mode == MODE_SHOW) begin
            if (n == 0) begin
                queue_reply('0, 1'b1, STATUS_EMPTY);
            end else begin
                for (i = 0; i < n; i++) queue_reply(list_codes[i], i + 1 == n, STATUS_OK);
            end
        end else begin
            queue_reply('0, 1'b1, st);
        end
    endtask

    always @(posedge aclk) begin : watch
        reply_t want;
        if (!aresetn) begin
            list_len = 0;
            replies_due.delete();
        end else begin
            // A result never belongs to an edit accepted at the same edge, so the
            // output side is checked before the new edit is predicted.
            if (m_valid && m_ready) begin
                results_seen++;
                // Fields are printed as color, last, status and length.
                if (replies_due.size() == 0) begin
                    mismatches++;
                    $display("%0t ERROR: expected no result, got %h %b %0d %0d",
                             $time, m_out_color, m_last, m_status, m_length);
                end else begin
                    want = replies_due.pop_front();
                    if (want.color !== m_out_color || want.last !== m_last ||
                        want.status !== m_status || want.len !== m_length) begin
                        mismatches++;
                        $display("%0t ERROR: expected %h %b %0d %0d, got %h %b %0d %0d",
                                 $time, want.color, want.last, want.status, want.len,
                                 m_out_color, m_last, m_status, m_length);
                    end
                end
            end
            if (s_valid && s_ready) begin
                items_seen++;
                edit_list(s_mode, s_color_code, s_position, s_position_end);
                if (list_len > peak_length) peak_length = list_len;
            end
        end
        outstanding <= replies_due.size();
    end

endmodule

// ----- tb/tb_sequence_list_editor_top.sv -----
// Testbench top for the sequence list editor: clock, reset, edit stimulus and
// output flow control; the verdict comes from sle_list_checker.
// Depends on sle_pkg, sle_list_checker and sequence_list_editor_top.
`timescale 1ns / 1ps

module tb_sequence_list_editor_top;
    import sle_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 200;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic [MODE_W-1:0]   s_mode         = '0;
    logic [CODE_W-1:0]   s_color_code   = '0;
    logic [POS_W-1:0]    s_position     = '0;
    logic [POS_W-1:0]    s_position_end = '0;
    logic                m_ready        = 1'b0;
    logic                s_ready;
    logic                m_valid;
    logic [CODE_W-1:0]   m_out_color;
    logic                m_last;
    logic [STATUS_W-1:0] m_status;
    logic [LEN_W-1:0]    m_length;

    logic hold_req       = 1'b0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;

    int mismatches, outstanding, items_seen, results_seen, peak_length, full_refusals;

    sequence_list_editor_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_color_code   (s_color_code),
        .s_position     (s_position),
        .s_position_end (s_position_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_color    (m_out_color),
        .m_last         (m_last),
        .m_status       (m_status),
        .m_length       (m_length)
    );

    sle_list_checker list_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_color_code   (s_color_code),
        .s_position     (s_position),
        .s_position_end (s_position_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_color    (m_out_color),
        .m_last         (m_last),
        .m_status       (m_status),
        .m_length       (m_length),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .items_seen     (items_seen),
        .results_seen   (results_seen),
        .peak_length    (peak_length),
        .full_refusals  (full_refusals)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Output flow control. A hold request parks m_ready low for a fixed stretch
    // so that the block backs up and stops taking edits.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req <= 1'b0;
                m_ready  <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Ends the run if no transfer happens on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t ERROR: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // A small palette makes repeated codes common enough for erase by colour.
    function automatic logic [CODE_W-1:0] pick_code();
        logic [CODE_W-1:0] c;
        case ($urandom_range(0, 9))
            0: c = 16'h0000;
            1: c = 16'hFFFF;
            2: c = 16'h1234;
            3: c = 16'hA5A5;
            4: c = 16'h5A5A;
            5: c = 16'h0001;
            default: c = CODE_W'($urandom_range(0, 65535));
        endcase
        return c;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        logic [POS_W-1:0] p;
        if ($urandom_range(0, 9) < 7) p = POS_W'($urandom_range(0, 40));
        else p = POS_W'($urandom_range(0, 127));
        return p;
    endfunction

    task automatic send_edit(input logic [MODE_W-1:0] mode, input logic [CODE_W-1:0] code,
                             input logic [POS_W-1:0] pos, input logic [POS_W-1:0] pos_end);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_color_code   <= code;
        s_position     <= pos;
        s_position_end <= pos_end;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random_edit();
        int                roll;
        logic [MODE_W-1:0] op;
        logic [POS_W-1:0]  left, right;
        roll = $urandom_range(0, 99);
        if (roll < 38)      op = MODE_INSERT;
        else if (roll < 53) op = MODE_ERASE_POS;
        else if (roll < 63) op = MODE_ERASE_COLOR;
        else if (roll < 80) op = MODE_REVERSE;
        else if (roll < 95) op = MODE_SHOW;
        else                op = MODE_SHOW + MODE_W'($urandom_range(1, 3));
        left = pick_pos();
        // Most reversals get a well-formed range; the rest take any pair.
        if (op == MODE_REVERSE && $urandom_range(0, 4) != 0)
            right = left + POS_W'($urandom_range(0, 30));
        else
            right = pick_pos();
        send_edit(op, pick_code(), left, right);
    endtask

    task automatic run_phase(input int sender_idle, input int receiver_stall, input int count);
        send_idle_pct  = sender_idle;
        recv_stall_pct = receiver_stall;
        repeat (count) send_random_edit();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed edits on an empty list, then on a short known list.
        send_edit(MODE_SHOW,        16'h0000, 7'd0,   7'd0);
        send_edit(MODE_ERASE_POS,   16'h0000, 7'd1,   7'd0);
        send_edit(MODE_ERASE_COLOR, 16'h0000, 7'd0,   7'd0);
        send_edit(MODE_REVERSE,     16'h0000, 7'd1,   7'd1);
        send_edit(MODE_INSERT,      16'h0000, 7'd0,   7'd0);
        send_edit(MODE_INSERT,      16'hFFFF, 7'd127, 7'd127);
        send_edit(MODE_INSERT,      16'h1234, 7'd1,   7'd0);
        send_edit(MODE_INSERT,      16'hA5A5, 7'd0,   7'd0);
        send_edit(MODE_INSERT,      16'h5A5A, 7'd64,  7'd0);
        send_edit(MODE_SHOW,        16'hFFFF, 7'd127, 7'd127);
        send_edit(MODE_REVERSE,     16'h0000, 7'd1,   7'd127);
        send_edit(MODE_REVERSE,     16'h0000, 7'd0,   7'd3);
        send_edit(MODE_REVERSE,     16'h0000, 7'd3,   7'd2);
        send_edit(MODE_REVERSE,     16'h0000, 7'd6,   7'd9);
        send_edit(MODE_REVERSE,     16'h0000, 7'd2,   7'd4);
        send_edit(MODE_SHOW,        16'h0000, 7'd0,   7'd0);
        send_edit(MODE_ERASE_POS,   16'h0000, 7'd0,   7'd0);
        send_edit(MODE_ERASE_POS,   16'h0000, 7'd127, 7'd0);
        send_edit(MODE_ERASE_POS,   16'h0000, 7'd1,   7'd0);
        send_edit(MODE_INSERT,      16'h1234, 7'd2,   7'd0);
        send_edit(MODE_ERASE_COLOR, 16'h1234, 7'd0,   7'd0);
        send_edit(MODE_ERASE_COLOR, 16'hBEEF, 7'd0,   7'd0);
        send_edit(MODE_SHOW + 3'd1, 16'hFFFF, 7'd127, 7'd127);
        send_edit(MODE_SHOW + 3'd2, 16'h0F0F, 7'd85,  7'd42);
        send_edit(MODE_SHOW + 3'd3, 16'hF0F0, 7'd42,  7'd85);
        send_edit(MODE_SHOW,        16'h0000, 7'd0,   7'd0);

        run_phase(0, 0, 50);
        run_phase(78, 0, 50);

        // Fill the list to capacity, push a few inserts past it and list it all.
        send_idle_pct  = 0;
        recv_stall_pct = 78;
        repeat (DEPTH + 4) send_edit(MODE_INSERT, pick_code(), pick_pos(), pick_pos());
        send_edit(MODE_SHOW, 16'h0000, 7'd0, 7'd0);
        run_phase(0, 78, 30);
        run_phase(16, 16, 50);

        // Keep offering edits back to back while the output is held off.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req <= 1'b1;
        repeat (24) send_random_edit();

        run_phase(0, 0, 30);
        send_edit(MODE_SHOW, 16'h0000, 7'd0, 7'd0);
        s_valid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Summary: %0d edits taken under four idling mixes and a long output hold.",
                 items_seen);
        $display("Summary: %0d results checked, list peaked at %0d, %0d inserts refused.",
                 results_seen, peak_length, full_refusals);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/sle_pkg.sv
hdl/sequence_list_editor_top.sv
tb/sle_list_checker.sv
tb/tb_sequence_list_editor_top.sv
